// ===== rtl/ftmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftmd_pkg
// Shared constants, payload types and the per-channel state row layout.
// ----------------------------------------------------------------------------
package ftmd_pkg;

  localparam int CHANNELS = 5;
  localparam int WIN      = 5;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [25:0] RATE_RESET  = 26'd6553600;
  localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;

  typedef logic [2:0]          chan_t;
  typedef logic [15:0]         sample_t;
  typedef logic [25:0]         rate_t;
  typedef logic signed [16:0]  diff_t;
  typedef logic signed [27:0]  force_t;
  typedef logic signed [39:0]  vel_t;
  typedef logic signed [49:0]  acc_t;
  typedef logic [CH_AW-1:0]    ch_idx_t;

  localparam force_t FORCE_MAX = 28'sh7FF_FFFF;
  localparam force_t FORCE_MIN = 28'sh800_0000;
  localparam acc_t   ACC_MAX   = 50'sh1_FFFF_FFFF_FFFF;
  localparam acc_t   ACC_MIN   = 50'sh2_0000_0000_0000;

  // one row per channel: offset, difference window (oldest first), two last forces
  typedef struct packed {
    sample_t              offset;
    diff_t  [WIN-1:0]     win;
    force_t [1:0]         hist;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// ===== rtl/ftmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftmd_if
// Valid/ready channels: sample input, result output and rate register write.
// ----------------------------------------------------------------------------
interface ftmd_sample_if;
  import ftmd_pkg::*;
  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t raw_sample;
  logic    calibrate;
  modport source (output valid, output channel, output raw_sample, output calibrate,
                  input ready);
  modport sink   (input valid, input channel, input raw_sample, input calibrate,
                  output ready);
endinterface

interface ftmd_result_if;
  import ftmd_pkg::*;
  logic   valid;
  logic   ready;
  chan_t  out_channel;
  force_t force_q16;
  vel_t   velocity_prev_q16;
  vel_t   velocity_q16;
  acc_t   acceleration_q16;
  modport source (output valid, output out_channel, output force_q16,
                  output velocity_prev_q16, output velocity_q16,
                  output acceleration_q16, input ready);
  modport sink   (input valid, input out_channel, input force_q16,
                  input velocity_prev_q16, input velocity_q16,
                  input acceleration_q16, output ready);
endinterface

interface ftmd_cfg_if;
  import ftmd_pkg::*;
  logic  valid;
  logic  ready;
  rate_t rate_q16;
  modport source (output valid, output rate_q16, input ready);
  modport sink   (input valid, input rate_q16, output ready);
endinterface

// ===== rtl/ftmd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/force_trimmed_mean_differentiator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_trimmed_mean_differentiator
// Per-channel five-point trimmed-mean force filter with rate-scaled first and
// second differences; channel state is one RAM row, read, updated, written back.
// ----------------------------------------------------------------------------
// sequencing: one sample in flight; a new sample is taken only in idle, after the
//   previous result has been loaded into the output register, which waits while
//   an earlier result beat waits for ready; the sequencer steps the row read, trim,
//   divide-by-15 multiply and the rate multiplies in turn, and a channel out of
//   range goes straight to the output state
// reset: synchronous; rate returns to 6553600, row valid bits clear so every
//   channel reads as zero state, no clearing pass
// ----------------------------------------------------------------------------
module force_trimmed_mean_differentiator (
  input  logic                 clk,
  input  logic                 rst,
  ftmd_sample_if.sink          sample,
  ftmd_result_if.source        result,
  ftmd_cfg_if.sink             cfg
);
  import ftmd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SUM, S_DIV, S_FORCE, S_VDIF, S_VMUL, S_VSAT,
    S_ADIF, S_AMUL, S_OUT
  } state_t;

  state_t              state;
  rate_t               rate;
  logic [CHANNELS-1:0] row_valid;

  chan_t   ch;
  sample_t raw;
  logic    cal;
  logic    in_range;
  row_t    row;

  logic        sum_neg;
  logic [18:0] sum_mag;
  logic        div_neg;
  logic [63:0] div_prod;
  force_t      frc;
  logic        d0_neg, d1_neg;
  logic [27:0] d0_mag, d1_mag;
  logic [53:0] p0, p1;
  vel_t        v0, v1;
  logic        a_neg;
  logic [39:0] a_mag;
  logic [45:0] a_lo_p, a_hi_p;

  logic    ram_re, ram_we;
  ch_idx_t ram_raddr, ch_idx;
  row_t    ram_rdata, ram_wdata;

  row_t             rd_row;
  sample_t          off_next;
  diff_t            diff_new;
  diff_t [WIN-1:0]  win_next;
  logic signed [19:0] mid_sum;
  force_t           force_c;
  logic [54:0]      r0_full, r1_full;
  logic [66:0]      a_total;
  logic [50:0]      a_r;
  acc_t             acc_c;

  assign ch_idx    = CH_AW'(ch);
  assign ram_re    = sample.valid && sample.ready;
  assign ram_raddr = CH_AW'(sample.channel);
  assign ram_we    = (state == S_FORCE);
  assign ram_wdata = '{offset: row.offset, win: row.win, hist: {force_c, row.hist[1]}};

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  ftmd_ram #(.WIDTH(ROW_W), .DEPTH(CHANNELS)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read stage: offset, new difference, shifted window
  always_comb begin
    rd_row   = row_valid[ch_idx] ? ram_rdata : '0;
    off_next = cal ? raw : rd_row.offset;
    diff_new = $signed({1'b0, raw}) - $signed({1'b0, off_next});
    for (int i = 0; i < WIN - 1; i++) begin
      win_next[i] = rd_row.win[i+1];
    end
    win_next[WIN-1] = diff_new;
  end

  // trimmed sum of the window
  always_comb begin
    logic signed [19:0] s;
    diff_t mx, mn;
    s  = '0;
    mx = row.win[0];
    mn = row.win[0];
    for (int i = 0; i < WIN; i++) begin
      s = s + {{3{row.win[i][16]}}, row.win[i]};
      if (row.win[i] > mx) mx = row.win[i];
      if (row.win[i] < mn) mn = row.win[i];
    end
    mid_sum = s - {{3{mx[16]}}, mx} - {{3{mn[16]}}, mn};
  end

  // quotient by 15 and force saturation
  always_comb begin
    logic [28:0] q;
    q = div_prod[63:35];
    if (!div_neg) begin
      force_c = (q > 29'(FORCE_MAX)) ? FORCE_MAX : force_t'(q);
    end else begin
      force_c = (q > 29'd134217728) ? FORCE_MIN : -force_t'(q);
    end
  end

  // velocity rounding, half away from zero
  assign r0_full = {1'b0, p0} + 55'h8000;
  assign r1_full = {1'b0, p1} + 55'h8000;

  // acceleration product, rounding and saturation
  always_comb begin
    a_total = {1'b0, a_hi_p, 20'd0} + {21'd0, a_lo_p} + 67'h8000;
    a_r     = a_total[66:16];
    if (!a_neg) begin
      acc_c = (a_r > 51'(ACC_MAX)) ? ACC_MAX : acc_t'(a_r);
    end else begin
      acc_c = (a_r > 51'h2_0000_0000_0000) ? ACC_MIN : -acc_t'(a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rate         <= RATE_RESET;
      row_valid    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        rate <= cfg.rate_q16;
      end
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ch       <= sample.channel;
            raw      <= sample.raw_sample;
            cal      <= sample.calibrate;
            in_range <= ({29'd0, sample.channel} < 32'(CHANNELS));
            state    <= ({29'd0, sample.channel} < 32'(CHANNELS)) ? S_READ : S_OUT;
          end
        end
        S_READ: begin
          row.offset <= off_next;
          row.win    <= win_next;
          row.hist   <= rd_row.hist;
          state      <= S_SUM;
        end
        S_SUM: begin
          sum_neg <= mid_sum[19];
          sum_mag <= mid_sum[19] ? 19'(-mid_sum) : 19'(mid_sum);
          state   <= S_DIV;
        end
        S_DIV: begin
          div_neg  <= sum_neg;
          div_prod <= ({sum_mag, 13'd0} + 32'd7) * DIV15_MAGIC;
          state    <= S_FORCE;
        end
        S_FORCE: begin
          frc               <= force_c;
          row_valid[ch_idx] <= 1'b1;
          state             <= S_VDIF;
        end
        S_VDIF: begin
          logic signed [28:0] e0, e1;
          e0 = {row.hist[1][27], row.hist[1]} - {row.hist[0][27], row.hist[0]};
          e1 = {frc[27], frc} - {row.hist[1][27], row.hist[1]};
          d0_neg <= e0[28];
          d1_neg <= e1[28];
          d0_mag <= e0[28] ? 28'(-e0) : 28'(e0);
          d1_mag <= e1[28] ? 28'(-e1) : 28'(e1);
          state  <= S_VMUL;
        end
        S_VMUL: begin
          p0    <= d0_mag * rate;
          p1    <= d1_mag * rate;
          state <= S_VSAT;
        end
        S_VSAT: begin
          v0    <= d0_neg ? -vel_t'(r0_full[54:16]) : vel_t'(r0_full[54:16]);
          v1    <= d1_neg ? -vel_t'(r1_full[54:16]) : vel_t'(r1_full[54:16]);
          state <= S_ADIF;
        end
        S_ADIF: begin
          logic signed [40:0] dv;
          dv = {v1[39], v1} - {v0[39], v0};
          a_neg <= dv[40];
          a_mag <= dv[40] ? 40'(-dv) : 40'(dv);
          state <= S_AMUL;
        end
        S_AMUL: begin
          a_lo_p <= a_mag[19:0] * rate;
          a_hi_p <= a_mag[39:20] * rate;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.out_channel <= ch;
            if (in_range) begin
              result.force_q16         <= frc;
              result.velocity_prev_q16 <= v0;
              result.velocity_q16      <= v1;
              result.acceleration_q16  <= acc_c;
            end else begin
              result.force_q16         <= '0;
              result.velocity_prev_q16 <= '0;
              result.velocity_q16      <= '0;
              result.acceleration_q16  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/force_trimmed_mean_differentiator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// force_trimmed_mean_differentiator_test
// Drives raw force samples through the trimmed-mean filter with random idle
// gaps on both handshakes, and checks every result beat against a software
// copy of the filter, the difference window and the rate-scaled derivatives.
// The rate register is swept through zero, one, its top values and randoms.
// ----------------------------------------------------------------------------
import ftmd_pkg::*;

typedef struct {
  chan_t  ch;
  force_t force_q;
  vel_t   vprev_q;
  vel_t   vnow_q;
  acc_t   acc_q;
} force_beat_t;

class force_chain_model;
  localparam longint FORCE_LIM = 64'd134217727;
  localparam longint VEL_LIM   = 64'd549755813887;
  localparam longint ACC_LIM   = 64'd562949953421311;

  rate_t       rate;
  sample_t     offset [CHANNELS];
  int          window [CHANNELS][WIN];
  longint      last_force [CHANNELS][2];
  force_beat_t awaited [$];
  int          checked;
  int          failures;

  function new();
    rate     = RATE_RESET;
    checked  = 0;
    failures = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      offset[c]        = '0;
      last_force[c][0] = 0;
      last_force[c][1] = 0;
      for (int k = 0; k < WIN; k++) window[c][k] = 0;
    end
  endfunction

  function void set_rate(rate_t value);
    rate = value;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // x * rate / 2^16, rounded half away from zero, clamped to -lim-1 .. lim
  function longint scale_by_rate(longint x, longint lim);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    longint unsigned cap;
    mag = (x < 0) ? -x : x;
    hi  = rate;
    hi  = hi >> 16;
    lo  = rate;
    lo  = lo & 64'hFFFF;
    r   = mag * hi + ((mag * lo + 64'h8000) >> 16);
    cap = (x < 0) ? lim + 1 : lim;
    if (r > cap) r = cap;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function void note_sample(chan_t ch, sample_t raw, logic cal);
    force_beat_t     want;
    int              sum;
    int              mx;
    int              mn;
    longint unsigned mag;
    longint unsigned q;
    longint          f_new;
    longint          f0;
    longint          f1;
    longint          v0;
    longint          v1;
    longint          a;
    want.ch      = ch;
    want.force_q = '0;
    want.vprev_q = '0;
    want.vnow_q  = '0;
    want.acc_q   = '0;
    if (ch < CHANNELS) begin
      if (cal) offset[ch] = raw;
      for (int k = 0; k < WIN - 1; k++) window[ch][k] = window[ch][k + 1];
      window[ch][WIN - 1] = int'(raw) - int'(offset[ch]);
      sum = 0;
      mx  = window[ch][0];
      mn  = window[ch][0];
      for (int k = 0; k < WIN; k++) begin
        sum += window[ch][k];
        if (window[ch][k] > mx) mx = window[ch][k];
        if (window[ch][k] < mn) mn = window[ch][k];
      end
      sum   = sum - mx - mn;
      mag   = (sum < 0) ? -sum : sum;
      q     = (mag * 8192 + 7) / 15;
      f_new = (sum < 0) ? -longint'(q) : longint'(q);
      if (f_new > FORCE_LIM) f_new = FORCE_LIM;
      if (f_new < -FORCE_LIM - 1) f_new = -FORCE_LIM - 1;
      f0 = last_force[ch][0];
      f1 = last_force[ch][1];
      last_force[ch][0] = f1;
      last_force[ch][1] = f_new;
      v0 = scale_by_rate(f1 - f0, VEL_LIM);
      v1 = scale_by_rate(f_new - f1, VEL_LIM);
      a  = scale_by_rate(v1 - v0, ACC_LIM);
      want.force_q = force_t'(f_new);
      want.vprev_q = vel_t'(v0);
      want.vnow_q  = vel_t'(v1);
      want.acc_q   = acc_t'(a);
    end
    awaited.push_back(want);
  endfunction

  function void check_result(force_beat_t got);
    force_beat_t want;
    if (awaited.size() == 0) begin
      failures++;
      if (failures <= 10) $display("result beat on channel %0d with none awaited", got.ch);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (want.ch !== got.ch || want.force_q !== got.force_q || want.vprev_q !== got.vprev_q ||
        want.vnow_q !== got.vnow_q || want.acc_q !== got.acc_q) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch expected ch %0d force %0d vprev %0d vel %0d acc %0d",
                 want.ch, want.force_q, want.vprev_q, want.vnow_q, want.acc_q);
        $display("         actual   ch %0d force %0d vprev %0d vel %0d acc %0d",
                 got.ch, got.force_q, got.vprev_q, got.vnow_q, got.acc_q);
      end
    end
  endfunction

  function void report_leftover();
    if (awaited.size() != 0) begin
      failures++;
      $display("%0d result beats never arrived", awaited.size());
    end
  endfunction
endclass

module force_trimmed_mean_differentiator_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftmd_sample_if sample_ch ();
  ftmd_result_if result_ch ();
  ftmd_cfg_if    cfg_ch ();

  force_trimmed_mean_differentiator dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  force_chain_model book;
  bit    hold_request = 1'b0;
  int    sent_count   = 0;
  int    rate_writes  = 0;
  chan_t focus_ch     = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d result beats outstanding", book.pending());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int pick_burst();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 12);
    else return $urandom_range(40, 150);
  endfunction

  function automatic chan_t pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return chan_t'($urandom_range(CHANNELS, 7));
    else if (r < 55) return focus_ch;
    else return chan_t'($urandom_range(0, CHANNELS - 1));
  endfunction

  function automatic sample_t pick_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // output side: random ready bursts, plus one long hold on request
  initial begin
    int left;
    bit rdy;
    left = 0;
    rdy  = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
        rdy  = 1'b1;
        left = 5;
        result_ch.ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else begin
        rdy  = !rdy;
        left = rdy ? pick_burst() : pick_gap();
        result_ch.ready <= rdy;
      end
    end
  end

  always @(posedge clk) begin
    force_beat_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.ch      = result_ch.out_channel;
      got.force_q = result_ch.force_q16;
      got.vprev_q = result_ch.velocity_prev_q16;
      got.vnow_q  = result_ch.velocity_q16;
      got.acc_q   = result_ch.acceleration_q16;
      book.check_result(got);
    end
  end

  // called at a rising edge; returns at a rising edge
  task automatic send_sample(chan_t ch, sample_t raw, logic cal, bit steady);
    int gap;
    sample_ch.valid      <= 1'b1;
    sample_ch.channel    <= ch;
    sample_ch.raw_sample <= raw;
    sample_ch.calibrate  <= cal;
    do @(posedge clk); while (!sample_ch.ready);
    book.note_sample(ch, raw, cal);
    sent_count++;
    gap = (steady || hold_request || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_rate(rate_t value);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.rate_q16 <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    book.set_rate(value);
    rate_writes++;
  endtask

  task automatic run_random(int count, bit with_hold);
    bit steady;
    steady   = ($urandom_range(0, 3) == 0);
    focus_ch = chan_t'($urandom_range(0, CHANNELS - 1));
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 5) hold_request = 1'b1;
      if ($urandom_range(0, 15) == 0) focus_ch = chan_t'($urandom_range(0, CHANNELS - 1));
      send_sample(pick_channel(), pick_raw(), ($urandom_range(0, 99) < 8), steady);
    end
  endtask

  initial begin
    book = new();
    sample_ch.valid      <= 1'b0;
    sample_ch.channel    <= '0;
    sample_ch.raw_sample <= '0;
    sample_ch.calibrate  <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.rate_q16      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // zero state, then a window full of maximum ties, then a minimum
    send_sample(3'd0, 16'h0000, 1'b0, 1'b0);
    repeat (4) send_sample(3'd0, 16'hFFFF, 1'b0, 1'b0);
    send_sample(3'd0, 16'h0000, 1'b0, 1'b0);
    // full-scale offset, negative differences
    send_sample(3'd1, 16'hFFFF, 1'b1, 1'b0);
    repeat (3) send_sample(3'd1, 16'h0000, 1'b0, 1'b0);
    send_sample(3'd1, 16'hFFFF, 1'b0, 1'b0);
    send_sample(3'd2, 16'h0001, 1'b0, 1'b0);
    repeat (3) send_sample(3'd2, 16'd100, 1'b0, 1'b0);
    send_sample(3'd3, 16'h8000, 1'b1, 1'b0);
    send_sample(3'd3, 16'h7FFF, 1'b0, 1'b0);
    send_sample(3'd4, 16'd12345, 1'b1, 1'b0);
    // channels past the last one must leave every state alone
    send_sample(3'd5, 16'hFFFF, 1'b1, 1'b0);
    send_sample(3'd6, 16'h0000, 1'b0, 1'b0);
    send_sample(3'd7, 16'hAAAA, 1'b1, 1'b0);
    send_sample(3'd4, 16'h5555, 1'b0, 1'b0);

    drain_results();
    write_rate('0);
    run_random(40, 1'b0);
    drain_results();
    write_rate(rate_t'(1));
    run_random(40, 1'b0);
    drain_results();
    write_rate(rate_t'(65536000));
    run_random(80, 1'b1);
    drain_results();
    write_rate('1);
    run_random(60, 1'b0);
    repeat (4) begin
      drain_results();
      write_rate(rate_t'($urandom_range(1, 65536000)));
      run_random(45, 1'b0);
    end

    drain_results();
    repeat (33) @(posedge clk);
    book.report_leftover();

    $display("%0d samples sent, %0d result beats checked, %0d rate writes",
             sent_count, book.checked, rate_writes);
    $display("rates zero, one, top of range and all ones; long output hold; %0d failures",
             book.failures);
    if (book.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
